/* hw/rtl/irb_pkg.sv */
// Shared types, constants and a helper function for the bilinear image rotation block.
package irb_pkg;

    localparam int DEF_MAX_WIDTH        = 256;
    localparam int DEF_MAX_HEIGHT       = 256;
    localparam int DEF_ANGLE_FRAC_BITS  = 14;
    localparam int DEF_INTERP_FRAC_BITS = 8;

    localparam int ANGLE_W    = 16;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 3 * 8;
    localparam int FIFO_DEPTH = 16;

    localparam logic signed [ANGLE_W-1:0] SIN_RESET  = 16'sd0;
    localparam logic signed [ANGLE_W-1:0] COS_RESET  = 16'sd16384;
    localparam logic [SIZE_W-1:0]         SIZE_RESET = 9'd256;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIN_ANGLE    = 3'd0,
        CFG_COS_ANGLE    = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } cfg_index_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input int unsigned max_size);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if (32'(v) > max_size) begin
            r = SIZE_W'(max_size);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/image_rotate_bilinear.sv */
// Top level of the bilinear image rotation block: four-bank source store and query pipeline.
//
// The block takes one beat per clock cycle while s_tready is high, loads and queries mixed in
// any order. A load writes one source pixel; a query returns one result beat through a
// 16-entry output queue, so up to 16 query results may be outstanding before s_tready drops.
// The source frame is split over four single-port-read banks by column and row parity, so the
// 2x2 neighborhood of a query is read from all four banks in the same cycle; loads are written
// in the same pipeline stage that queries read, which keeps every query consistent with the
// loads taken before it. The store is not cleared by reset and a query must only touch pixels
// that were loaded. Configuration writes are taken at once (cfg_ready is always high) and must
// only be made while no query is in flight.
module image_rotate_bilinear
    import irb_pkg::*;
#(
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
    parameter int ANGLE_FRAC_BITS  = DEF_ANGLE_FRAC_BITS,
    parameter int INTERP_FRAC_BITS = DEF_INTERP_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // col[7:0], row[15:8], pixel_in[23:16]
    input  logic                  s_tuser,   // kind[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // pixel_out[7:0]
    output logic                  m_tuser,   // inside_res[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PROD_W     = (POS_W + 1) + ANGLE_W;
    localparam int CTR_W      = 1 + POS_W + ANGLE_FRAC_BITS;
    localparam int SUM_W      = ((PROD_W > CTR_W) ? PROD_W : CTR_W) + 2;
    localparam int IPW        = SUM_W - ANGLE_FRAC_BITS;
    localparam int FRAC_W     = INTERP_FRAC_BITS + 1;
    localparam int MUL1_W     = FRAC_W + 1 + PIX_W + 1;
    localparam int M_W        = PIX_W + 2;
    localparam int MUL2_W     = FRAC_W + 1 + M_W + 1;
    localparam int P_W        = M_W + 1;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int OUT_W      = FP_W + 1;

    localparam logic [FRAC_W-1:0]        ONE_I = FRAC_W'(2 ** INTERP_FRAC_BITS);
    localparam logic signed [MUL1_W-1:0] RND1  = MUL1_W'(2 ** (INTERP_FRAC_BITS - 1));
    localparam logic signed [MUL2_W-1:0] RND2  = MUL2_W'(2 ** (INTERP_FRAC_BITS - 1));

    // Configuration registers.
    logic signed [ANGLE_W-1:0] sin_reg, cos_reg;
    logic [POS_W-1:0]          center_x_reg, center_y_reg;
    logic [SIZE_W-1:0]         frame_width_reg, frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sin_reg          <= SIN_RESET;
            cos_reg          <= COS_RESET;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            frame_width_reg  <= clamp_size(SIZE_RESET, MAX_WIDTH);
            frame_height_reg <= clamp_size(SIZE_RESET, MAX_HEIGHT);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SIN_ANGLE:    sin_reg          <= $signed(cfg_data[ANGLE_W-1:0]);
                CFG_COS_ANGLE:    cos_reg          <= $signed(cfg_data[ANGLE_W-1:0]);
                CFG_CENTER_X:     center_x_reg     <= cfg_data[POS_W-1:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_data[POS_W-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= clamp_size(cfg_data[SIZE_W-1:0], MAX_WIDTH);
                CFG_FRAME_HEIGHT: frame_height_reg <= clamp_size(cfg_data[SIZE_W-1:0], MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    // Input acceptance and result credit.
    logic [OUT_W-1:0] outstanding_reg, outstanding_next;
    logic             s_beat, m_beat, q_beat;

    assign s_tready = (outstanding_reg < OUT_W'(FIFO_DEPTH));
    assign s_beat   = s_tvalid && s_tready;
    assign q_beat   = s_beat && (s_tuser == KIND_QUERY);
    assign m_beat   = m_tvalid && m_tready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (q_beat && !m_beat) begin
            outstanding_next = outstanding_reg + OUT_W'(1);
        end else if (!q_beat && m_beat) begin
            outstanding_next = outstanding_reg - OUT_W'(1);
        end
    end

    // Stage valids.
    logic v0_reg, v1_reg, v2_reg, wr_en3_reg, rd_en3_reg, qv4_reg, qv5_reg, qv6_reg, qv7_reg;
    logic wr_en3_next, rd_en3_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            wr_en3_reg      <= 1'b0;
            rd_en3_reg      <= 1'b0;
            qv4_reg         <= 1'b0;
            qv5_reg         <= 1'b0;
            qv6_reg         <= 1'b0;
            qv7_reg         <= 1'b0;
        end else begin
            outstanding_reg <= outstanding_next;
            v0_reg          <= s_beat;
            v1_reg          <= v0_reg;
            v2_reg          <= v1_reg;
            wr_en3_reg      <= wr_en3_next;
            rd_en3_reg      <= rd_en3_next;
            qv4_reg         <= rd_en3_reg;
            qv5_reg         <= qv4_reg;
            qv6_reg         <= qv5_reg;
            qv7_reg         <= qv6_reg;
        end
    end

    // Stage 0: registered input beat.
    logic             kind0_reg, kind1_reg, kind2_reg;
    logic [POS_W-1:0] col0_reg, row0_reg, col1_reg, row1_reg, col2_reg, row2_reg;
    logic [PIX_W-1:0] pix0_reg, pix1_reg, pix2_reg;

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            kind0_reg <= s_tuser;
            col0_reg  <= s_tdata[POS_W-1:0];
            row0_reg  <= s_tdata[2*POS_W-1:POS_W];
            pix0_reg  <= s_tdata[2*POS_W+PIX_W-1:2*POS_W];
        end
    end

    // Stage 1: rotation products.
    logic signed [POS_W:0]    dx0, dy0;
    logic signed [PROD_W-1:0] pcx_reg, psy_reg, psx_reg, pcy_reg;

    assign dx0 = $signed({1'b0, col0_reg}) - $signed({1'b0, center_x_reg});
    assign dy0 = $signed({1'b0, row0_reg}) - $signed({1'b0, center_y_reg});

    always_ff @(posedge aclk) begin
        kind1_reg <= kind0_reg;
        col1_reg  <= col0_reg;
        row1_reg  <= row0_reg;
        pix1_reg  <= pix0_reg;
        pcx_reg   <= dx0 * cos_reg;
        psy_reg   <= dy0 * sin_reg;
        psx_reg   <= dx0 * sin_reg;
        pcy_reg   <= dy0 * cos_reg;
    end

    // Stage 2: source coordinates.
    logic signed [CTR_W-1:0] cx_term, cy_term;
    logic signed [SUM_W-1:0] x2_reg, y2_reg;

    assign cx_term = $signed({1'b0, center_x_reg, {ANGLE_FRAC_BITS{1'b0}}});
    assign cy_term = $signed({1'b0, center_y_reg, {ANGLE_FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        kind2_reg <= kind1_reg;
        col2_reg  <= col1_reg;
        row2_reg  <= row1_reg;
        pix2_reg  <= pix1_reg;
        x2_reg    <= pcx_reg + psy_reg + cx_term;
        y2_reg    <= pcy_reg - psx_reg + cy_term;
    end

    // Stage 2 to 3: inside test, base, weights and bank addresses.
    logic [IPW-1:0]              ipx, ipy;
    logic [INTERP_FRAC_BITS-1:0] fx_raw, fy_raw;
    logic                        inside_next, edge_x, edge_y;
    logic [SIZE_W-1:0]           bx_next, by_next;
    logic [SIZE_W:0]             bx_p1, by_p1;
    logic [FRAC_W-1:0]           fx_next, fy_next;
    logic                        load_in_store;
    logic [BANK_AW-1:0]          load_addr;
    logic [3:0][BANK_AW-1:0]     addr3_next, addr3_reg;
    logic [1:0]                  wr_bank3_reg;
    logic [PIX_W-1:0]            wr_data3_reg;
    logic                        inside3_reg, bx0_3_reg, by0_3_reg;
    logic [FRAC_W-1:0]           fx3_reg, fy3_reg;

    assign ipx = x2_reg[SUM_W-1:ANGLE_FRAC_BITS];
    assign ipy = y2_reg[SUM_W-1:ANGLE_FRAC_BITS];

    if (ANGLE_FRAC_BITS >= INTERP_FRAC_BITS) begin : g_frac_down
        assign fx_raw = x2_reg[ANGLE_FRAC_BITS-1 -: INTERP_FRAC_BITS];
        assign fy_raw = y2_reg[ANGLE_FRAC_BITS-1 -: INTERP_FRAC_BITS];
    end else begin : g_frac_up
        assign fx_raw = {x2_reg[ANGLE_FRAC_BITS-1:0],
                         {(INTERP_FRAC_BITS - ANGLE_FRAC_BITS){1'b0}}};
        assign fy_raw = {y2_reg[ANGLE_FRAC_BITS-1:0],
                         {(INTERP_FRAC_BITS - ANGLE_FRAC_BITS){1'b0}}};
    end

    always_comb begin
        inside_next = !x2_reg[SUM_W-1] && !y2_reg[SUM_W-1]
                      && (ipx < IPW'(frame_width_reg)) && (ipy < IPW'(frame_height_reg));
        bx_p1   = {1'b0, ipx[SIZE_W-1:0]} + (SIZE_W+1)'(1);
        by_p1   = {1'b0, ipy[SIZE_W-1:0]} + (SIZE_W+1)'(1);
        edge_x  = bx_p1 >= {1'b0, frame_width_reg};
        edge_y  = by_p1 >= {1'b0, frame_height_reg};
        bx_next = edge_x ? frame_width_reg - SIZE_W'(2) : ipx[SIZE_W-1:0];
        by_next = edge_y ? frame_height_reg - SIZE_W'(2) : ipy[SIZE_W-1:0];
        fx_next = edge_x ? ONE_I : {1'b0, fx_raw};
        fy_next = edge_y ? ONE_I : {1'b0, fy_raw};
        if (!inside_next) begin
            bx_next = '0;
            by_next = '0;
        end
        load_in_store = (32'(col2_reg) < 32'(MAX_WIDTH)) && (32'(row2_reg) < 32'(MAX_HEIGHT));
        load_addr     = BANK_AW'(row2_reg[POS_W-1:1]) * BANK_AW'(HALF_W)
                        + BANK_AW'(col2_reg[POS_W-1:1]);
        wr_en3_next   = v2_reg && (kind2_reg == KIND_LOAD) && load_in_store;
        rd_en3_next   = v2_reg && (kind2_reg == KIND_QUERY);
    end

    for (genvar k = 0; k < 4; k++) begin : g_addr
        logic [SIZE_W:0] col_sel, row_sel;
        assign col_sel = (bx_next[0] == k[0]) ? {1'b0, bx_next} : {1'b0, bx_next} + (SIZE_W+1)'(1);
        assign row_sel = (by_next[0] == k[1]) ? {1'b0, by_next} : {1'b0, by_next} + (SIZE_W+1)'(1);
        assign addr3_next[k] = (kind2_reg == KIND_LOAD) ? load_addr
                               : BANK_AW'(row_sel[SIZE_W:1]) * BANK_AW'(HALF_W)
                                 + BANK_AW'(col_sel[SIZE_W:1]);
    end

    always_ff @(posedge aclk) begin
        addr3_reg    <= addr3_next;
        wr_bank3_reg <= {row2_reg[0], col2_reg[0]};
        wr_data3_reg <= pix2_reg;
        inside3_reg  <= inside_next;
        bx0_3_reg    <= bx_next[0];
        by0_3_reg    <= by_next[0];
        fx3_reg      <= fx_next;
        fy3_reg      <= fy_next;
    end

    // Stage 3 to 4: four source banks, bank index {row parity, column parity}.
    logic [3:0][PIX_W-1:0] bank_q;

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [PIX_W-1:0] mem [BANK_DEPTH];
        logic [PIX_W-1:0] q_reg;
        always_ff @(posedge aclk) begin
            if (wr_en3_reg && (wr_bank3_reg == 2'(k))) begin
                mem[addr3_reg[k]] <= wr_data3_reg;
            end
            if (rd_en3_reg) begin
                q_reg <= mem[addr3_reg[k]];
            end
        end
        assign bank_q[k] = q_reg;
    end

    logic              inside4_reg, bx0_4_reg, by0_4_reg;
    logic [FRAC_W-1:0] fx4_reg, fy4_reg;

    always_ff @(posedge aclk) begin
        inside4_reg <= inside3_reg;
        bx0_4_reg   <= bx0_3_reg;
        by0_4_reg   <= by0_3_reg;
        fx4_reg     <= fx3_reg;
        fy4_reg     <= fy3_reg;
    end

    // Stage 4 to 5: vertical blend products.
    logic [PIX_W-1:0]         a4, b4, c4, d4, a5_reg, c5_reg;
    logic signed [PIX_W:0]    dba4, ddc4;
    logic signed [FRAC_W:0]   fy4_s;
    logic signed [MUL1_W-1:0] pba5_reg, pdc5_reg;
    logic                     inside5_reg;
    logic [FRAC_W-1:0]        fx5_reg;

    assign a4    = bank_q[{by0_4_reg, bx0_4_reg}];
    assign b4    = bank_q[{~by0_4_reg, bx0_4_reg}];
    assign c4    = bank_q[{by0_4_reg, ~bx0_4_reg}];
    assign d4    = bank_q[{~by0_4_reg, ~bx0_4_reg}];
    assign dba4  = $signed({1'b0, b4}) - $signed({1'b0, a4});
    assign ddc4  = $signed({1'b0, d4}) - $signed({1'b0, c4});
    assign fy4_s = $signed({1'b0, fy4_reg});

    always_ff @(posedge aclk) begin
        a5_reg      <= a4;
        c5_reg      <= c4;
        pba5_reg    <= fy4_s * dba4;
        pdc5_reg    <= fy4_s * ddc4;
        inside5_reg <= inside4_reg;
        fx5_reg     <= fx4_reg;
    end

    // Stage 5 to 6: rounded vertical blends.
    logic signed [MUL1_W-1:0] t_ba5, t_dc5, r_ba5, r_dc5;
    logic signed [M_W-1:0]    m1_6_reg, m2_6_reg;
    logic                     inside6_reg;
    logic [FRAC_W-1:0]        fx6_reg;

    assign t_ba5 = pba5_reg + RND1;
    assign t_dc5 = pdc5_reg + RND1;
    assign r_ba5 = t_ba5 >>> INTERP_FRAC_BITS;
    assign r_dc5 = t_dc5 >>> INTERP_FRAC_BITS;

    always_ff @(posedge aclk) begin
        m1_6_reg    <= $signed({2'b00, a5_reg}) + $signed(r_ba5[M_W-1:0]);
        m2_6_reg    <= $signed({2'b00, c5_reg}) + $signed(r_dc5[M_W-1:0]);
        inside6_reg <= inside5_reg;
        fx6_reg     <= fx5_reg;
    end

    // Stage 6 to 7: horizontal blend product.
    logic signed [M_W:0]      dm6;
    logic signed [FRAC_W:0]   fx6_s;
    logic signed [MUL2_W-1:0] prod7_reg;
    logic signed [M_W-1:0]    m1_7_reg;
    logic                     inside7_reg;

    assign dm6   = m2_6_reg - m1_6_reg;
    assign fx6_s = $signed({1'b0, fx6_reg});

    always_ff @(posedge aclk) begin
        prod7_reg   <= fx6_s * dm6;
        m1_7_reg    <= m1_6_reg;
        inside7_reg <= inside6_reg;
    end

    // Stage 7: final rounding, saturation and result queue.
    logic signed [MUL2_W-1:0] t7, r7;
    logic signed [P_W-1:0]    p7;
    logic [PIX_W-1:0]         pix7;
    logic [PIX_W:0]           fifo_mem [FIFO_DEPTH];
    logic [FP_W:0]            wr_ptr_reg, rd_ptr_reg;

    assign t7 = prod7_reg + RND2;
    assign r7 = t7 >>> INTERP_FRAC_BITS;
    assign p7 = m1_7_reg + $signed(r7[P_W-1:0]);

    always_comb begin
        if (!inside7_reg || p7 < 0) begin
            pix7 = '0;
        end else if (p7 > $signed(P_W'(2 ** PIX_W - 1))) begin
            pix7 = '1;
        end else begin
            pix7 = p7[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (qv7_reg) begin
            fifo_mem[wr_ptr_reg[FP_W-1:0]] <= {inside7_reg, pix7};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (qv7_reg) begin
                wr_ptr_reg <= wr_ptr_reg + (FP_W+1)'(1);
            end
            if (m_beat) begin
                rd_ptr_reg <= rd_ptr_reg + (FP_W+1)'(1);
            end
        end
    end

    assign m_tvalid = (wr_ptr_reg != rd_ptr_reg);
    assign m_tdata  = fifo_mem[rd_ptr_reg[FP_W-1:0]][PIX_W-1:0];
    assign m_tuser  = fifo_mem[rd_ptr_reg[FP_W-1:0]][PIX_W];

endmodule

/* hw/rtl/irb_checker.sv */
// Port-level checker for the bilinear image rotation block, bound to its top level.
module irb_checker
    import irb_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             cfg_ready
);

    logic [7:0] pending_reg;
    logic       q_beat, m_beat;

    assign q_beat = s_tvalid && s_tready && (s_tuser == KIND_QUERY);
    assign m_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (q_beat && !m_beat) begin
            pending_reg <= pending_reg + 8'd1;
        end else if (!q_beat && m_beat) begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    // A stalled result beat keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every result beat answers an earlier query beat.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result beat without an outstanding query");

    // A point outside the frame reads as zero.
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("outside result carries a nonzero pixel");

    // Reset empties the result side and leaves the configuration port open.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && cfg_ready)
        else $error("result valid or configuration blocked after reset");

endmodule

bind image_rotate_bilinear irb_checker u_irb_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for image_rotate_bilinear, predicting every rotated pixel it streams.
module tb;
    import irb_pkg::*;

    localparam int ANGLE_SHIFT = DEF_ANGLE_FRAC_BITS;
    localparam int BLEND_SHIFT = DEF_INTERP_FRAC_BITS;
    localparam longint ANGLE_ONE = longint'(1) << ANGLE_SHIFT;
    localparam int BLEND_ONE = 1 << BLEND_SHIFT;
    localparam int BLEND_HALF = 1 << (BLEND_SHIFT - 1);
    localparam int FRAME_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    typedef struct {
        logic             kind;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] value;
    } pixel_beat_t;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             in_frame;
    } rotated_pixel_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } reg_write_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] sin_q;
        logic signed [ANGLE_W-1:0] cos_q;
        logic [POS_W-1:0]          cx;
        logic [POS_W-1:0]          cy;
        logic [SIZE_W-1:0]         fw;
        logic [SIZE_W-1:0]         fh;
    } rotation_t;

    typedef struct {
        bit in_frame;
        bit edge_hit;
        int bx;
        int by;
        int fx;
        int fy;
    } source_point_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pixel_beat_t    pixel_beats[$];
    rotated_pixel_t outstanding_pixels[$];
    reg_write_t     reg_writes[$];

    bit [PIX_W-1:0] src_img [FRAME_CELLS];
    bit             planned_written [FRAME_CELLS];
    rotation_t      active_rot = '{SIN_RESET, COS_RESET, '0, '0, SIZE_RESET, SIZE_RESET};

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int n_fails = 0;
    int n_queued = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_inside = 0;
    int n_edge = 0;
    int n_settings = 1;

    image_rotate_bilinear dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pixel_index(input int x, input int y);
        return y * DEF_MAX_WIDTH + x;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] raw,
                                                    input int limit);
        logic [SIZE_W-1:0] v;
        v = raw[SIZE_W-1:0];
        if (v < SIZE_W'(2)) return SIZE_W'(2);
        if (int'(v) > limit) return SIZE_W'(limit);
        return v;
    endfunction

    function automatic longint half_up(input longint v);
        return (v + BLEND_HALF) >>> BLEND_SHIFT;
    endfunction

    function automatic source_point_t map_back(input rotation_t r, input logic [POS_W-1:0] col,
                                               input logic [POS_W-1:0] row);
        source_point_t sp;
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        sp = '{default: 0};
        dx = longint'(col) - longint'(r.cx);
        dy = longint'(row) - longint'(r.cy);
        sx = dx * longint'(r.cos_q) + dy * longint'(r.sin_q) + longint'(r.cx) * ANGLE_ONE;
        sy = -dx * longint'(r.sin_q) + dy * longint'(r.cos_q) + longint'(r.cy) * ANGLE_ONE;
        if (sx < 0 || sy < 0 || sx >= longint'(r.fw) * ANGLE_ONE
                || sy >= longint'(r.fh) * ANGLE_ONE) begin
            return sp;
        end
        sp.in_frame = 1'b1;
        sp.bx = int'(sx >>> ANGLE_SHIFT);
        sp.by = int'(sy >>> ANGLE_SHIFT);
        sp.fx = int'((sx & (ANGLE_ONE - 1)) >>> (ANGLE_SHIFT - BLEND_SHIFT));
        sp.fy = int'((sy & (ANGLE_ONE - 1)) >>> (ANGLE_SHIFT - BLEND_SHIFT));
        if (sp.bx >= int'(r.fw) - 1) begin
            sp.bx = int'(r.fw) - 2;
            sp.fx = BLEND_ONE;
            sp.edge_hit = 1'b1;
        end
        if (sp.by >= int'(r.fh) - 1) begin
            sp.by = int'(r.fh) - 2;
            sp.fy = BLEND_ONE;
            sp.edge_hit = 1'b1;
        end
        return sp;
    endfunction

    function automatic rotated_pixel_t rotate_pixel(input logic [POS_W-1:0] col,
                                                    input logic [POS_W-1:0] row);
        source_point_t  sp;
        rotated_pixel_t res;
        longint a;
        longint b;
        longint c;
        longint d;
        longint m1;
        longint m2;
        longint p;
        sp = map_back(active_rot, col, row);
        res = '{value: '0, in_frame: 1'b0};
        if (!sp.in_frame) return res;
        n_inside++;
        if (sp.edge_hit) n_edge++;
        a = longint'(src_img[pixel_index(sp.bx, sp.by)]);
        b = longint'(src_img[pixel_index(sp.bx, sp.by + 1)]);
        c = longint'(src_img[pixel_index(sp.bx + 1, sp.by)]);
        d = longint'(src_img[pixel_index(sp.bx + 1, sp.by + 1)]);
        m1 = a + half_up(sp.fy * (b - a));
        m2 = c + half_up(sp.fy * (d - c));
        p = m1 + half_up(sp.fx * (m2 - m1));
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        res.value = PIX_W'(p);
        res.in_frame = 1'b1;
        return res;
    endfunction

    function automatic void queue_load(input int x, input int y, input logic [PIX_W-1:0] v);
        pixel_beats.push_back('{KIND_LOAD, POS_W'(x), POS_W'(y), v});
        planned_written[pixel_index(x, y)] = 1'b1;
        n_queued++;
    endfunction

    // Queues a query, first loading any neighbor of the source point not yet written, so no query reads an empty cell.
    function automatic void add_query(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
        source_point_t sp;
        sp = map_back(active_rot, col, row);
        if (sp.in_frame) begin
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 2; i++) begin
                    if (!planned_written[pixel_index(sp.bx + i, sp.by + j)]) begin
                        queue_load(sp.bx + i, sp.by + j, PIX_W'($urandom_range(255)));
                    end
                end
            end
        end
        pixel_beats.push_back('{KIND_QUERY, col, row, PIX_W'($urandom_range(255))});
        n_queued++;
    endfunction

    task automatic settle();
        while (pixel_beats.size() != 0 || s_tvalid || outstanding_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int sin_v, input int cos_v, input int cx_v, input int cy_v,
                             input int fw_raw, input int fh_raw, input int send_pct,
                             input int recv_pct, input int n_beats);
        int start;
        int r;
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] rw;
        source_point_t sp;
        reg_writes.push_back('{CFG_SIN_ANGLE, CFG_DATA_W'(sin_v)});
        reg_writes.push_back('{CFG_COS_ANGLE, CFG_DATA_W'(cos_v)});
        reg_writes.push_back('{CFG_CENTER_X, CFG_DATA_W'(cx_v)});
        reg_writes.push_back('{CFG_CENTER_Y, CFG_DATA_W'(cy_v)});
        reg_writes.push_back('{CFG_FRAME_WIDTH, CFG_DATA_W'(fw_raw)});
        reg_writes.push_back('{CFG_FRAME_HEIGHT, CFG_DATA_W'(fh_raw)});
        while (reg_writes.size() != 0 || cfg_valid) @(posedge aclk);
        n_settings++;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = n_queued;
        while (n_queued - start < n_beats) begin
            r = $urandom_range(99);
            if (r < 10) begin
                queue_load($urandom_range(255), $urandom_range(255), PIX_W'($urandom_range(255)));
            end else begin
                for (int t = 0; t < 16; t++) begin
                    c = POS_W'($urandom_range(255));
                    rw = POS_W'($urandom_range(255));
                    sp = map_back(active_rot, c, rw);
                    if (sp.in_frame || r >= 80) break;
                end
                add_query(c, rw);
            end
        end
        settle();
    endtask

    always @(posedge aclk) begin : beat_drive
        pixel_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pixel_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {b.value, b.row, b.col};
                s_tuser <= b.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : reg_drive
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || cfg_ready) begin
            if (reg_writes.size() != 0) begin
                w = reg_writes.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.index;
                cfg_data <= w.value;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        rotated_pixel_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIN_ANGLE: active_rot.sin_q = cfg_data;
                    CFG_COS_ANGLE: active_rot.cos_q = cfg_data;
                    CFG_CENTER_X: active_rot.cx = cfg_data[POS_W-1:0];
                    CFG_CENTER_Y: active_rot.cy = cfg_data[POS_W-1:0];
                    CFG_FRAME_WIDTH: active_rot.fw = clamp_dim(cfg_data, DEF_MAX_WIDTH);
                    CFG_FRAME_HEIGHT: active_rot.fh = clamp_dim(cfg_data, DEF_MAX_HEIGHT);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_LOAD) begin
                    src_img[pixel_index(s_tdata[7:0], s_tdata[15:8])] = s_tdata[23:16];
                    n_loads++;
                end else begin
                    outstanding_pixels.push_back(rotate_pixel(s_tdata[7:0], s_tdata[15:8]));
                    n_queries++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (outstanding_pixels.size() == 0) begin
                    $error("result beat with no query outstanding: pixel_out %0d", m_tdata);
                    n_fails++;
                end else begin
                    want = outstanding_pixels.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("pixel_out: expected %0d, got %0d", want.value, m_tdata);
                        n_fails++;
                    end
                    if (m_tuser !== want.in_frame) begin
                        $error("inside_res: expected %0d, got %0d", want.in_frame, m_tuser);
                        n_fails++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)
                || (pixel_beats.size() == 0 && !s_tvalid && outstanding_pixels.size() == 0
                    && reg_writes.size() == 0 && !cfg_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The reset rotation is the identity over the full frame.
        queue_load(0, 0, 8'hFF);
        queue_load(1, 0, 8'h00);
        queue_load(0, 1, 8'h00);
        queue_load(1, 1, 8'hFF);
        queue_load(255, 255, 8'hAA);
        queue_load(254, 255, 8'h55);
        queue_load(255, 254, 8'h0F);
        queue_load(254, 254, 8'hF0);
        add_query(8'd0, 8'd0);
        add_query(8'd255, 8'd255);
        add_query(8'd255, 8'd0);
        add_query(8'd0, 8'd255);
        add_query(8'd1, 8'd1);
        settle();

        run_phase(8192, 14189, 128, 128, 256, 256, 0, 0, 55);
        reg_writes.push_back('{CFG_UNMAPPED_A, 16'hFFFF});
        reg_writes.push_back('{CFG_UNMAPPED_B, 16'h0001});
        run_phase(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  $urandom_range(255), $urandom_range(255), 0, 511, 80, 0, 55);
        run_phase(-16384, -16384, 255, 255, 17, 1, 0, 80, 50);
        run_phase(16384, 0, 128, 128, 257, 256, 30, 30, 55);
        run_phase(0, 16384, 0, 0, 2, 2, 0, 0, 30);
        run_phase(16384, 16384, 0, 0, 256, 256, 0, 0, 40);
        run_phase(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  $urandom_range(511), 80, 0, 55);
        run_phase(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  $urandom_range(511), 0, 80, 55);
        run_phase(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  $urandom_range(255), $urandom_range(255), $urandom_range(511),
                  $urandom_range(511), 30, 30, 55);

        $display("Streamed %0d pixel loads and %0d rotation queries across %0d register settings.",
                 n_loads, n_queries, n_settings);
        $display("%0d queries mapped inside the frame, %0d of them onto the last column or row.",
                 n_inside, n_edge);
        if (n_fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/irb_pkg.sv
hw/rtl/image_rotate_bilinear.sv
hw/rtl/irb_checker.sv
tb/tb.sv
